/* hdl/lbci_pkg.sv */
// Package for the LED blink-code indicator: phase codes, state and result
// types, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package lbci_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ON    = 2'd1,
    PH_OFF   = 2'd2,
    PH_PAUSE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_ON_TICKS    = 2'd0,
    REG_OFF_TICKS   = 2'd1,
    REG_PAUSE_TICKS = 2'd2
  } reg_idx_t;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  localparam logic [7:0] ON_TICKS_RST    = 8'd18;
  localparam logic [7:0] OFF_TICKS_RST   = 8'd18;
  localparam logic [7:0] PAUSE_TICKS_RST = 8'd80;
  localparam logic [7:0] BLINKS_MAX      = 8'd255;

  typedef struct packed {
    logic [7:0] on_ticks;
    logic [7:0] off_ticks;
    logic [7:0] pause_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] ticks_left;
    logic [7:0] blinks_done;
    logic [7:0] shown_code;
    logic       led_level;
  } state_t;

  // Packed so that led_on sits in bit 0, as on the output tdata.
  typedef struct packed {
    logic [7:0] current_error;
    logic       led_on;
  } result_t;

endpackage

/* hdl/lbci_step.sv */
// Next-state logic of the blink-code indicator for one word.
// Depends on lbci_pkg.
`timescale 1ns / 1ps

module lbci_step (
  input  lbci_pkg::state_t  state_i,
  input  lbci_pkg::cfg_t    cfg_i,
  input  logic              kind_i,
  input  logic [7:0]        code_i,
  output lbci_pkg::state_t  state_o,
  output lbci_pkg::result_t result_o
);

  always_comb begin
    state_o = state_i;
    if (kind_i == lbci_pkg::KIND_SET) begin
      if (code_i == 8'd0) begin
        state_o.phase     = lbci_pkg::PH_IDLE;
        state_o.led_level = 1'b0;
      end else if (code_i != state_i.shown_code) begin
        state_o.phase     = lbci_pkg::PH_OFF;
        state_o.led_level = 1'b0;
      end
      state_o.shown_code = code_i;
    end else if (state_i.ticks_left != 8'd0) begin
      state_o.ticks_left = state_i.ticks_left - 8'd1;
    end else begin
      unique case (state_i.phase)
        lbci_pkg::PH_ON: begin
          if (state_i.blinks_done != lbci_pkg::BLINKS_MAX) begin
            state_o.blinks_done = state_i.blinks_done + 8'd1;
          end
          state_o.phase      = lbci_pkg::PH_OFF;
          state_o.ticks_left = cfg_i.off_ticks;
          state_o.led_level  = 1'b0;
        end
        lbci_pkg::PH_OFF: begin
          if (state_i.blinks_done >= state_i.shown_code) begin
            state_o.phase      = lbci_pkg::PH_PAUSE;
            state_o.ticks_left = cfg_i.pause_ticks;
          end else begin
            state_o.phase      = lbci_pkg::PH_ON;
            state_o.ticks_left = cfg_i.on_ticks;
            state_o.led_level  = 1'b1;
          end
        end
        lbci_pkg::PH_PAUSE: begin
          state_o.blinks_done = 8'd0;
          state_o.phase       = lbci_pkg::PH_ON;
          state_o.ticks_left  = cfg_i.on_ticks;
          state_o.led_level   = 1'b1;
        end
        lbci_pkg::PH_IDLE: begin
          state_o.phase = lbci_pkg::PH_IDLE;
        end
        default: begin
          state_o.phase = lbci_pkg::PH_IDLE;
        end
      endcase
    end
    result_o.led_on        = state_o.led_level;
    result_o.current_error = state_o.shown_code;
  end

endmodule

/* hdl/lbci_skid.sv */
// Two-entry output stage: result register plus skid register.
// Depends on lbci_pkg.
`timescale 1ns / 1ps

module lbci_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  lbci_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output lbci_pkg::result_t data_o,
  input  logic              taken_i
);

  logic              out_v_r,  out_v_nxt;
  logic              skid_v_r, skid_v_nxt;
  lbci_pkg::result_t out_d_r,  out_d_nxt;
  lbci_pkg::result_t skid_d_r, skid_d_nxt;

  assign ready_o = !skid_v_r;
  assign valid_o = out_v_r;
  assign data_o  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (out_v_r && !taken_i) begin
      // stalled: park a new word in the skid slot
      if (push_i) begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = data_i;
      end
    end else if (skid_v_r) begin
      out_v_nxt  = 1'b1;
      out_d_nxt  = skid_d_r;
      skid_v_nxt = 1'b0;
    end else begin
      out_v_nxt = push_i;
      out_d_nxt = data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

/* hdl/led_blink_code_indicator_unit.sv */
// Top level of the LED blink-code indicator: state and register file,
// next-state logic and output stage. Depends on lbci_pkg, lbci_step, lbci_skid.
`timescale 1ns / 1ps

// Usage
//  - in_*: one word per timer tick (in_tuser = 0) or per new error code
//    (in_tuser = 1, code in in_tdata). Taken when in_tvalid && in_tready.
//  - out_*: exactly one word per input word, in order: LED level in bit 0,
//    code now shown in bits 8:1.
//  - cfg_*: on, off and pause lengths, index 0..2; index 3 is ignored.
//    Write only while the block is idle.
//  - Output: the result of an accepted word is registered in the output stage.
//  - Throughput: one word per cycle unless stalled; the state update is a single
//    decrement/compare pass between state registers, so nothing iterates.
//  - Stall: a two-entry output stage holds results; in_tready drops only
//    once both the result and the skid register are full, so one more word
//    is taken while a result waits.
//  - Reset (rst_n low, synchronous): idle phase, LED dark, code 0, counters
//    cleared, lengths back to 18/18/80, output stage empty.
module led_blink_code_indicator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] code to show
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] led_on, [8:1] current_error, [15:9] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  lbci_pkg::cfg_t    cfg_r;
  lbci_pkg::state_t  state_r, state_nxt;
  lbci_pkg::result_t step_res;
  lbci_pkg::result_t out_res;
  logic              accept;

  assign accept = in_tvalid && in_tready;

  lbci_step u_step (
    .state_i  (state_r),
    .cfg_i    (cfg_r),
    .kind_i   (in_tuser),
    .code_i   (in_tdata),
    .state_o  (state_nxt),
    .result_o (step_res)
  );

  lbci_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (accept),
    .data_i  (step_res),
    .ready_o (in_tready),
    .valid_o (out_tvalid),
    .data_o  (out_res),
    .taken_i (out_tready)
  );

  assign out_tdata = {7'd0, out_res};

  // Indicator state: advances once per accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= lbci_pkg::PH_IDLE;
      state_r.ticks_left  <= 8'd0;
      state_r.blinks_done <= 8'd0;
      state_r.shown_code  <= 8'd0;
      state_r.led_level   <= 1'b0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // Phase length registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_ticks    <= lbci_pkg::ON_TICKS_RST;
      cfg_r.off_ticks   <= lbci_pkg::OFF_TICKS_RST;
      cfg_r.pause_ticks <= lbci_pkg::PAUSE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbci_pkg::REG_ON_TICKS:    cfg_r.on_ticks    <= cfg_wdata;
        lbci_pkg::REG_OFF_TICKS:   cfg_r.off_ticks   <= cfg_wdata;
        lbci_pkg::REG_PAUSE_TICKS: cfg_r.pause_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule
